// ----- rtl/bspc_pkg.sv -----
// Shared types, constants and helper functions of the button speed PWM controller.
package bspc_pkg;

  // Width of the wait arithmetic; wide enough for any supported timer width.
  localparam int WAIT_W = 24;

  localparam logic [2:0] FACTORY_RESET = 3'd3;
  localparam logic [15:0] PWM_UNIT_RESET = 16'd100;
  localparam logic [15:0] RUN_DEB_RESET = 16'd50;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd2000;
  localparam logic [15:0] SETUP_DEB_RESET = 16'd500;

  localparam logic [7:0] SEG_BLANK = 8'hff;
  localparam logic [7:0] SEG_DOT_MASK = 8'h7f;

  localparam logic [1:0] MODE_RUN = 2'd0;
  localparam logic [1:0] MODE_STOP = 2'd1;
  localparam logic [1:0] MODE_ENG = 2'd2;

  localparam logic [2:0] CFG_PWM_UNIT = 3'd0;
  localparam logic [2:0] CFG_RUN_DEB = 3'd1;
  localparam logic [2:0] CFG_LONG_PRESS = 3'd2;
  localparam logic [2:0] CFG_SETUP_DEB = 3'd3;
  localparam logic [2:0] CFG_FACTORY = 3'd4;

  typedef enum logic [3:0] {
    PH_TOP           = 4'd0,
    PH_ON            = 4'd1,
    PH_OFF           = 4'd2,
    PH_RUN_MINUS     = 4'd3,
    PH_RUN_PLUS_CHK  = 4'd4,
    PH_RUN_PLUS      = 4'd5,
    PH_STOP_LONG     = 4'd6,
    PH_ENG_TOP       = 4'd7,
    PH_ENG_PLUS      = 4'd8,
    PH_ENG_MINUS_CHK = 4'd9,
    PH_ENG_MINUS     = 4'd10,
    PH_ENG_POWER     = 4'd11
  } phase_t;

  typedef struct packed {
    logic [3:0] speed;
    logic [3:0] maxl;
    logic [2:0] defl;
    logic [7:0] seg;
    logic       drive;
    logic [1:0] mode;
  } bspc_vals_t;

  typedef struct packed {
    logic              hit;
    phase_t            ph;
    logic [WAIT_W-1:0] load;
  } bspc_wait_t;

  typedef struct packed {
    logic [15:0] unit;
    logic [15:0] run_deb;
    logic [15:0] long_press;
    logic [15:0] setup_deb;
    logic [2:0]  factory;
  } bspc_cfg_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d, input logic dot);
    logic [7:0] code;
    case (d)
      4'd0:    code = 8'hc0;
      4'd1:    code = 8'hf9;
      4'd2:    code = 8'ha4;
      4'd3:    code = 8'hb0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hf8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    if (dot && d <= 4'd9) begin
      code = code & SEG_DOT_MASK;
    end
    return code;
  endfunction

  function automatic logic [2:0] clamp_factory(input logic [2:0] f);
    logic [2:0] r;
    if (f < 3'd2) begin
      r = 3'd2;
    end else if (f > 3'd5) begin
      r = 3'd5;
    end else begin
      r = f;
    end
    return r;
  endfunction

  // Timer load for a nonzero wait of n ticks, saturated at tmax.
  function automatic logic [WAIT_W-1:0] wait_load(input logic [WAIT_W-1:0] n,
                                                 input logic [WAIT_W-1:0] tmax);
    logic [WAIT_W-1:0] s;
    s = (n > tmax) ? tmax : n;
    return s - WAIT_W'(1);
  endfunction

  function automatic logic [3:0] max_of(input logic [2:0] d);
    return 4'({1'b0, d, 1'b0} - 5'd1);
  endfunction

endpackage

// ----- rtl/bspc_run_seg.sv -----
// Run-mode chain: PWM off phase, then the minus and plus debounce checks.
module bspc_run_seg (
  input  bspc_pkg::phase_t             entry,
  input  bspc_pkg::bspc_vals_t         vals_in,
  input  logic                         minus_p,
  input  logic                         plus_p,
  input  logic [15:0]                  unit,
  input  logic [15:0]                  run_deb,
  input  logic [bspc_pkg::WAIT_W-1:0]  tmax,
  output bspc_pkg::bspc_vals_t         vals_out,
  output bspc_pkg::bspc_wait_t         wt
);
  import bspc_pkg::*;

  logic [3:0]        rest;
  logic [19:0]       off_ticks;
  logic              go_off;
  logic              go_rm;
  logic              go_pc;
  logic              go_rp;
  logic [3:0]        spd;

  always_comb begin
    vals_out = vals_in;
    wt = '{hit: 1'b0, ph: PH_TOP, load: '0};
    rest = (vals_in.maxl >= vals_in.speed) ? (vals_in.maxl - vals_in.speed) : 4'd0;
    off_ticks = 20'(rest) * 20'(unit);
    go_off = (entry == PH_OFF);
    go_rm = (entry == PH_RUN_MINUS);
    go_pc = (entry == PH_RUN_PLUS_CHK);
    go_rp = (entry == PH_RUN_PLUS);
    spd = vals_in.speed;

    if (entry == PH_ON) begin
      vals_out.drive = 1'b0;
      if (off_ticks != 20'd0) begin
        wt = '{hit: 1'b1, ph: PH_OFF, load: wait_load(WAIT_W'(off_ticks), tmax)};
      end else begin
        go_off = 1'b1;
      end
    end

    if (go_off) begin
      if (minus_p) begin
        if (run_deb != 16'd0) begin
          wt = '{hit: 1'b1, ph: PH_RUN_MINUS, load: wait_load(WAIT_W'(run_deb), tmax)};
        end else begin
          go_rm = 1'b1;
        end
      end else begin
        go_pc = 1'b1;
      end
    end

    if (go_rm) begin
      if (minus_p) begin
        spd = (spd != 4'd0) ? spd - 4'd1 : 4'd0;
        if (spd == 4'd0) begin
          spd = vals_in.maxl;
        end
      end
      go_pc = 1'b1;
    end

    if (go_pc && plus_p) begin
      if (run_deb != 16'd0) begin
        wt = '{hit: 1'b1, ph: PH_RUN_PLUS, load: wait_load(WAIT_W'(run_deb), tmax)};
      end else begin
        go_rp = 1'b1;
      end
    end

    if (go_rp && plus_p) begin
      spd = spd + 4'd1;
      if (spd > vals_in.maxl || spd == 4'd0) begin
        spd = 4'd1;
      end
    end

    vals_out.speed = spd;
  end

endmodule

// ----- rtl/bspc_eng_seg.sv -----
// Engineering-mode chain: default level step, long-minus exit and power exit.
module bspc_eng_seg (
  input  bspc_pkg::phase_t             entry,
  input  bspc_pkg::bspc_vals_t         vals_in,
  input  logic                         pwr_on,
  input  logic                         minus_p,
  input  logic                         plus_p,
  input  logic [15:0]                  long_press,
  input  logic [2:0]                   factory,
  input  logic [bspc_pkg::WAIT_W-1:0]  tmax,
  output bspc_pkg::bspc_vals_t         vals_out,
  output bspc_pkg::bspc_wait_t         wt,
  output bspc_pkg::phase_t             exit_ph
);
  import bspc_pkg::*;

  logic       go_mchk;
  logic       go_em;
  logic       go_pw;
  logic [3:0] d_inc;
  logic [2:0] fl;

  always_comb begin
    vals_out = vals_in;
    wt = '{hit: 1'b0, ph: PH_TOP, load: '0};
    exit_ph = PH_ENG_TOP;
    go_mchk = (entry == PH_ENG_MINUS_CHK);
    go_em = (entry == PH_ENG_MINUS);
    go_pw = (entry == PH_ENG_POWER);
    d_inc = {1'b0, vals_in.defl} + 4'd1;
    fl = clamp_factory(factory);

    if (entry == PH_ENG_PLUS) begin
      if (plus_p) begin
        vals_out.defl = (d_inc >= 4'd6 || d_inc < 4'd2) ? 3'd2 : d_inc[2:0];
      end
      go_mchk = 1'b1;
    end

    if (go_mchk) begin
      if (minus_p) begin
        if (long_press != 16'd0) begin
          wt = '{hit: 1'b1, ph: PH_ENG_MINUS, load: wait_load(WAIT_W'(long_press), tmax)};
        end else begin
          go_em = 1'b1;
        end
      end else begin
        go_pw = 1'b1;
      end
    end

    if (go_em) begin
      if (minus_p) begin
        vals_out.speed = {1'b0, vals_out.defl};
        vals_out.maxl = max_of(vals_out.defl);
        vals_out.mode = MODE_STOP;
        exit_ph = PH_TOP;
      end else begin
        go_pw = 1'b1;
      end
    end

    if (go_pw && pwr_on) begin
      vals_out.defl = fl;
      vals_out.speed = {1'b0, fl};
      vals_out.maxl = max_of(fl);
      vals_out.mode = MODE_STOP;
      exit_ph = PH_TOP;
    end
  end

endmodule

// ----- rtl/bspc_core.sv -----
// Controller state, wait timer and the per-tick sequencing of the mode chains.
module bspc_core #(
  parameter int TIMER_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  power_pin,
  input  logic                  plus_pin,
  input  logic                  minus_pin,
  input  bspc_pkg::bspc_cfg_t   cfg,
  output bspc_pkg::bspc_vals_t  vals_nxt
);
  import bspc_pkg::*;

  localparam logic [WAIT_W-1:0] TMAX = WAIT_W'((32'd1 << TIMER_BITS) - 32'd1);

  bspc_vals_t             vals_r;
  phase_t                 phase_r;
  phase_t                 phase_nxt;
  logic [TIMER_BITS-1:0]  timer_r;
  logic [TIMER_BITS-1:0]  timer_nxt;

  logic       pwr_on;
  logic       minus_p;
  logic       plus_p;

  bspc_vals_t run_t_vals;
  bspc_wait_t run_t_wt;
  bspc_vals_t eng_t_vals;
  bspc_wait_t eng_t_wt;
  phase_t     eng_t_exit;

  bspc_vals_t s1;
  bspc_wait_t tail_wt;
  phase_t     top_sel;

  bspc_vals_t on_vals;
  bspc_vals_t off_vals;
  bspc_vals_t eng_vals;
  logic [19:0] on_ticks;
  phase_t     eng_entry;
  bspc_vals_t run_p_vals;
  bspc_wait_t run_p_wt;
  bspc_vals_t eng_p_vals;
  bspc_wait_t eng_p_wt;
  phase_t     eng_p_exit;

  bspc_wait_t pass_wt;

  assign pwr_on = ~power_pin;
  assign minus_p = plus_pin & ~minus_pin;
  assign plus_p = ~plus_pin & minus_pin;

  // Tail of a pass that resumes after a wait.
  bspc_run_seg u_run_tail (
    .entry(phase_r), .vals_in(vals_r), .minus_p(minus_p), .plus_p(plus_p),
    .unit(cfg.unit), .run_deb(cfg.run_deb), .tmax(TMAX),
    .vals_out(run_t_vals), .wt(run_t_wt)
  );

  bspc_eng_seg u_eng_tail (
    .entry(phase_r), .vals_in(vals_r), .pwr_on(pwr_on), .minus_p(minus_p),
    .plus_p(plus_p), .long_press(cfg.long_press), .factory(cfg.factory), .tmax(TMAX),
    .vals_out(eng_t_vals), .wt(eng_t_wt), .exit_ph(eng_t_exit)
  );

  always_comb begin
    s1 = vals_r;
    tail_wt = '{hit: 1'b0, ph: PH_TOP, load: '0};
    top_sel = PH_TOP;
    unique case (phase_r) inside
      PH_TOP: begin
        top_sel = PH_TOP;
      end
      PH_ENG_TOP: begin
        top_sel = PH_ENG_TOP;
      end
      PH_ON, PH_OFF, PH_RUN_MINUS, PH_RUN_PLUS_CHK, PH_RUN_PLUS: begin
        s1 = run_t_vals;
        tail_wt = run_t_wt;
        top_sel = PH_TOP;
      end
      PH_STOP_LONG: begin
        if (minus_p) begin
          s1.mode = MODE_ENG;
          top_sel = PH_ENG_TOP;
        end
      end
      PH_ENG_PLUS, PH_ENG_MINUS_CHK, PH_ENG_MINUS, PH_ENG_POWER: begin
        s1 = eng_t_vals;
        tail_wt = eng_t_wt;
        top_sel = eng_t_exit;
      end
      default: begin
        top_sel = PH_TOP;
      end
    endcase
  end

  // Full pass from a loop top.
  always_comb begin
    on_vals = s1;
    on_vals.mode = MODE_RUN;
    on_vals.seg = seg_of(s1.speed, 1'b0);
    on_vals.drive = 1'b1;
    on_ticks = 20'(s1.speed) * 20'(cfg.unit);

    off_vals = s1;
    off_vals.mode = MODE_STOP;
    off_vals.seg = SEG_BLANK;
    off_vals.drive = 1'b0;
    off_vals.speed = {1'b0, s1.defl};

    eng_vals = s1;
    eng_vals.mode = MODE_ENG;
    eng_vals.seg = seg_of({1'b0, s1.defl}, 1'b1);
    eng_entry = plus_p ? PH_ENG_PLUS : PH_ENG_MINUS_CHK;
  end

  bspc_run_seg u_run_pass (
    .entry(PH_ON), .vals_in(on_vals), .minus_p(minus_p), .plus_p(plus_p),
    .unit(cfg.unit), .run_deb(cfg.run_deb), .tmax(TMAX),
    .vals_out(run_p_vals), .wt(run_p_wt)
  );

  bspc_eng_seg u_eng_pass (
    .entry(eng_entry), .vals_in(eng_vals), .pwr_on(pwr_on), .minus_p(minus_p),
    .plus_p(plus_p), .long_press(cfg.long_press), .factory(cfg.factory), .tmax(TMAX),
    .vals_out(eng_p_vals), .wt(eng_p_wt), .exit_ph(eng_p_exit)
  );

  always_comb begin
    vals_nxt = vals_r;
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    pass_wt = '{hit: 1'b0, ph: PH_TOP, load: '0};

    if (timer_r != '0) begin
      timer_nxt = timer_r - TIMER_BITS'(1);
    end else if (tail_wt.hit) begin
      vals_nxt = s1;
      pass_wt = tail_wt;
    end else if (top_sel == PH_TOP) begin
      if (pwr_on) begin
        if (on_ticks != 20'd0) begin
          vals_nxt = on_vals;
          pass_wt = '{hit: 1'b1, ph: PH_ON, load: wait_load(WAIT_W'(on_ticks), TMAX)};
        end else begin
          vals_nxt = run_p_vals;
          pass_wt = run_p_wt;
          phase_nxt = PH_TOP;
        end
      end else begin
        vals_nxt = off_vals;
        phase_nxt = PH_TOP;
        if (minus_p) begin
          if (cfg.long_press != 16'd0) begin
            pass_wt = '{hit: 1'b1, ph: PH_STOP_LONG,
                        load: wait_load(WAIT_W'(cfg.long_press), TMAX)};
          end else begin
            vals_nxt.mode = MODE_ENG;
            phase_nxt = PH_ENG_TOP;
          end
        end
      end
    end else begin
      if (plus_p && cfg.setup_deb != 16'd0) begin
        vals_nxt = eng_vals;
        pass_wt = '{hit: 1'b1, ph: PH_ENG_PLUS,
                    load: wait_load(WAIT_W'(cfg.setup_deb), TMAX)};
      end else begin
        vals_nxt = eng_p_vals;
        pass_wt = eng_p_wt;
        phase_nxt = eng_p_exit;
      end
    end

    if (pass_wt.hit) begin
      phase_nxt = pass_wt.ph;
      timer_nxt = pass_wt.load[TIMER_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vals_r <= '{speed: {1'b0, FACTORY_RESET}, maxl: max_of(FACTORY_RESET),
                  defl: FACTORY_RESET, seg: SEG_BLANK, drive: 1'b0, mode: MODE_STOP};
      phase_r <= PH_TOP;
      timer_r <= '0;
    end else if (step) begin
      vals_r <= vals_nxt;
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step && timer_r != '0) |=> ($stable(phase_r) && $stable(vals_r)))
    else $error("state changed while a wait was running");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vals_r.speed != 4'd0 && vals_r.speed <= vals_r.maxl))
    else $error("speed level outside 1..max");

  a_default_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vals_r.defl >= 3'd2 && vals_r.defl <= 3'd5))
    else $error("default level outside 2..5");

  a_idle_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(timer_r) && $stable(phase_r)))
    else $error("state moved without a tick");
`endif

endmodule

// ----- rtl/button_speed_pwm_controller_top.sv -----
// Top level of the button speed PWM controller: stream ports, configuration and output register.
// Every input transaction is one time tick carrying the raw power switch, plus and minus
// pins; every tick produces exactly one result transaction with the wheel drive bit, the
// active-low seven-segment pattern, the mode (0 running, 1 stopped, 2 engineering) and the
// current speed level. The block takes one tick per clock cycle unless the output stalls: a
// tick is registered on entry, the whole mode sequence for that tick is resolved by one pass of
// combinational logic in the core, and the result lands in the output register when the tick is
// executed, which waits while a result is untaken. The output register lets a new tick enter
// while an earlier result is still waiting to be taken. Configuration writes go through their
// own channel, are always ready, and should be issued only while no tick is in flight.
module button_speed_pwm_controller_top #(
  parameter int TIMER_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] power_pin, [1] plus_pin, [2] minus_pin, [7:3] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [0] wheel_drive, [8:1] segments, [10:9] mode, [14:11] level, [15] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bspc_pkg::*;

  // Configuration registers; a write to an unknown index is ignored.
  bspc_cfg_t cfg_r;

  // Input stage and output stage of the two-register pipeline.
  logic       s1_valid_r;
  logic [2:0] s1_pins_r;
  logic       out_valid_r;
  logic [15:0] out_data_r;

  logic       advance;
  logic       step;
  bspc_vals_t vals_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{unit: PWM_UNIT_RESET, run_deb: RUN_DEB_RESET,
                 long_press: LONG_PRESS_RESET, setup_deb: SETUP_DEB_RESET,
                 factory: FACTORY_RESET};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PWM_UNIT:   cfg_r.unit <= cfg_data;
        CFG_RUN_DEB:    cfg_r.run_deb <= cfg_data;
        CFG_LONG_PRESS: cfg_r.long_press <= cfg_data;
        CFG_SETUP_DEB:  cfg_r.setup_deb <= cfg_data;
        CFG_FACTORY:    cfg_r.factory <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // The output register can take a new result when empty or being drained this cycle.
  assign advance = ~out_valid_r | out_tready;
  // The tick in the input register is executed when it can move into the output register.
  assign step = s1_valid_r & advance;
  assign in_tready = ~s1_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_pins_r <= in_tdata[2:0];
    end
    if (step) begin
      out_data_r <= {1'b0, vals_nxt.speed, vals_nxt.mode, vals_nxt.seg, vals_nxt.drive};
    end
  end

  bspc_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .step(step),
    .power_pin(s1_pins_r[0]),
    .plus_pin(s1_pins_r[1]),
    .minus_pin(s1_pins_r[2]),
    .cfg(cfg_r),
    .vals_nxt(vals_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule
